/* rtl/vtrd_pkg.sv */
// vtrd_pkg: shared widths, codes, controller/datapath handshake structs and
// the digit-to-ASCII function for the radix digit converter.
// No dependencies.
package vtrd_pkg;

  // Fixed-point format of the value and the fraction precision limit
  localparam int INT_BITS        = 32;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 30;

  // Port widths
  localparam int PORT_W     = 32;
  localparam int RADIX_W    = 6;
  localparam int PREC_W     = 5;
  localparam int CHAR_W     = 7;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // Digit stack: radix two gives one digit per integer bit
  localparam int STACK_DEPTH = INT_BITS;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DCNT_W      = $clog2(INT_BITS);
  localparam int FCNT_W      = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int PROD_W      = FRAC_BITS + RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [PREC_W-1:0]  PREC_RESET  = PREC_W'(10);
  localparam logic [PREC_W-1:0]  PREC_MAX    = PREC_W'(MAX_FRAC_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 7'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX       = 1'b0,
    CFG_FRAC_DIGITS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_POP,
    ST_DOT,
    ST_FRAC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic pop;
    logic dot;
    logic frac_step;
    logic last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_int_zero;
    logic div_done;
    logic quot_zero;
    logic depth_one;
    logic frac_zero;
    logic frac_next_zero;
    logic frac_cnt_last;
    logic prec_zero;
  } stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] v);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(v);
    if (v < RADIX_W'(10)) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A + ext - CHAR_W'(10);
    end
  endfunction

endpackage

/* rtl/vtrd_ctrl.sv */
// vtrd_ctrl: sequencer for the radix digit converter. Walks the divide,
// push, pop, point and fraction phases and issues datapath commands.
// Depends on vtrd_pkg.
module vtrd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  vtrd_pkg::stat_t stat,
  output vtrd_pkg::cmd_t  cmd,
  output logic            busy
);

  vtrd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != vtrd_pkg::ST_IDLE);
    unique case (state)
      vtrd_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.in_int_zero ? vtrd_pkg::ST_POP : vtrd_pkg::ST_DIV;
        end
      end
      vtrd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = vtrd_pkg::ST_PUSH;
        end
      end
      vtrd_pkg::ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = stat.quot_zero ? vtrd_pkg::ST_POP : vtrd_pkg::ST_DIV;
      end
      vtrd_pkg::ST_POP: begin
        cmd.pop  = 1'b1;
        cmd.last = stat.depth_one && stat.frac_zero;
        if (stat.depth_one) begin
          state_next = stat.frac_zero ? vtrd_pkg::ST_IDLE : vtrd_pkg::ST_DOT;
        end
      end
      vtrd_pkg::ST_DOT: begin
        cmd.dot    = 1'b1;
        cmd.last   = stat.prec_zero;
        state_next = stat.prec_zero ? vtrd_pkg::ST_IDLE : vtrd_pkg::ST_FRAC;
      end
      vtrd_pkg::ST_FRAC: begin
        cmd.frac_step = 1'b1;
        cmd.last      = stat.frac_next_zero || stat.frac_cnt_last;
        if (cmd.last) begin
          state_next = vtrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vtrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/vtrd_dpath.sv */
// vtrd_dpath: datapath of the radix digit converter: config registers,
// bit-serial divider, digit stack, fraction multiplier and output register.
// Depends on vtrd_pkg.
module vtrd_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vtrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vtrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [vtrd_pkg::PORT_W-1:0]         int_part,
  input  logic [vtrd_pkg::PORT_W-1:0]         frac_part,
  input  vtrd_pkg::cmd_t                      cmd,
  output vtrd_pkg::stat_t                     stat,
  output logic                                strobe,
  output logic [vtrd_pkg::CHAR_W-1:0]         char_code,
  output logic                                last
);

  logic [vtrd_pkg::RADIX_W-1:0]   radix_cfg;
  logic [vtrd_pkg::PREC_W-1:0]    prec_cfg;
  logic [vtrd_pkg::RADIX_W-1:0]   radix_eff;
  logic [vtrd_pkg::PREC_W-1:0]    prec_eff;
  logic [vtrd_pkg::RADIX_W-1:0]   radix_r;
  logic [vtrd_pkg::PREC_W-1:0]    prec_r;
  logic [vtrd_pkg::INT_BITS-1:0]  quot;
  logic [vtrd_pkg::RADIX_W-1:0]   rem;
  logic [vtrd_pkg::DCNT_W-1:0]    dcnt;
  logic [vtrd_pkg::FRAC_BITS-1:0] frac;
  logic [vtrd_pkg::FCNT_W-1:0]    fcnt;
  logic [vtrd_pkg::DEPTH_W-1:0]   depth;
  logic [vtrd_pkg::RADIX_W-1:0]   stack [vtrd_pkg::STACK_DEPTH];

  logic [vtrd_pkg::INT_BITS-1:0]  int_in;
  logic [vtrd_pkg::FRAC_BITS-1:0] frac_in;
  logic [vtrd_pkg::RADIX_W:0]     trial;
  logic                           trial_ge;
  logic [vtrd_pkg::PROD_W-1:0]    prod;
  logic [vtrd_pkg::RADIX_W-1:0]   frac_digit;
  logic [vtrd_pkg::FRAC_BITS-1:0] frac_next;
  logic [vtrd_pkg::DEPTH_W-1:0]   top_idx;
  logic [vtrd_pkg::RADIX_W-1:0]   top_digit;
  logic [vtrd_pkg::CHAR_W-1:0]    char_next;

  // Drop bits above the configured fixed-point widths
  assign int_in  = int_part[vtrd_pkg::INT_BITS-1:0];
  assign frac_in = frac_part[vtrd_pkg::FRAC_BITS-1:0];

  // Saturate the configuration into its legal range
  always_comb begin
    priority if (radix_cfg < vtrd_pkg::RADIX_MIN) begin
      radix_eff = vtrd_pkg::RADIX_MIN;
    end else if (radix_cfg > vtrd_pkg::RADIX_MAX) begin
      radix_eff = vtrd_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix_cfg;
    end
    prec_eff = (prec_cfg > vtrd_pkg::PREC_MAX) ? vtrd_pkg::PREC_MAX : prec_cfg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_cfg <= vtrd_pkg::RADIX_RESET;
      prec_cfg  <= vtrd_pkg::PREC_RESET;
    end else if (cfg_we) begin
      unique case (vtrd_pkg::cfg_idx_t'(cfg_index))
        vtrd_pkg::CFG_RADIX:       radix_cfg <= cfg_data[vtrd_pkg::RADIX_W-1:0];
        vtrd_pkg::CFG_FRAC_DIGITS: prec_cfg  <= cfg_data[vtrd_pkg::PREC_W-1:0];
        default: ;
      endcase
    end
  end

  // Restoring division, one quotient bit per cycle
  assign trial    = {rem, quot[vtrd_pkg::INT_BITS-1]};
  assign trial_ge = (trial >= {1'b0, radix_r});

  // Fraction step: exact product, integer bits are the digit
  assign prod       = vtrd_pkg::PROD_W'(frac) * vtrd_pkg::PROD_W'(radix_r);
  assign frac_digit = prod[vtrd_pkg::PROD_W-1 -: vtrd_pkg::RADIX_W];
  assign frac_next  = prod[vtrd_pkg::FRAC_BITS-1:0];

  assign top_idx   = depth - vtrd_pkg::DEPTH_W'(1);
  assign top_digit = stack[top_idx[vtrd_pkg::PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r <= radix_eff;
      prec_r  <= prec_eff;
      quot    <= int_in;
      frac    <= frac_in;
      rem     <= '0;
      dcnt    <= '0;
      depth   <= (int_in == '0) ? vtrd_pkg::DEPTH_W'(1) : '0;
    end else if (cmd.div_step) begin
      quot <= {quot[vtrd_pkg::INT_BITS-2:0], trial_ge};
      rem  <= trial_ge ? vtrd_pkg::RADIX_W'(trial - {1'b0, radix_r})
                       : trial[vtrd_pkg::RADIX_W-1:0];
      dcnt <= dcnt + vtrd_pkg::DCNT_W'(1);
    end else if (cmd.push) begin
      depth <= depth + vtrd_pkg::DEPTH_W'(1);
      rem   <= '0;
      dcnt  <= '0;
    end else if (cmd.pop) begin
      depth <= top_idx;
    end else if (cmd.dot) begin
      fcnt <= '0;
    end else if (cmd.frac_step) begin
      frac <= frac_next;
      fcnt <= fcnt + vtrd_pkg::FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (int_in == '0)) begin
      stack[0] <= '0;
    end else if (cmd.push) begin
      stack[depth[vtrd_pkg::PTR_W-1:0]] <= rem;
    end
  end

  always_comb begin
    stat.in_int_zero    = (int_in == '0);
    stat.div_done       = (dcnt == vtrd_pkg::DCNT_W'(vtrd_pkg::INT_BITS - 1));
    stat.quot_zero      = (quot == '0);
    stat.depth_one      = (depth == vtrd_pkg::DEPTH_W'(1));
    stat.frac_zero      = (frac == '0);
    stat.frac_next_zero = (frac_next == '0);
    stat.frac_cnt_last  = (vtrd_pkg::PREC_W'(fcnt + vtrd_pkg::FCNT_W'(1)) == prec_r);
    stat.prec_zero      = (prec_r == '0);
  end

  always_comb begin
    priority if (cmd.dot) begin
      char_next = vtrd_pkg::CHAR_DOT;
    end else if (cmd.frac_step) begin
      char_next = vtrd_pkg::digit_char(frac_digit);
    end else begin
      char_next = vtrd_pkg::digit_char(top_digit);
    end
  end

  // Output register: one transfer per emitted character
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.pop || cmd.dot || cmd.frac_step;
    end
  end

  always_ff @(posedge clk) begin
    char_code <= char_next;
    last      <= cmd.last;
  end

endmodule

/* rtl/value_to_radix_digits_unit.sv */
// value_to_radix_digits_unit: converts a Q32.32 value into its ASCII digit string.
// Each integer digit comes out of the bit-serial divider and is pushed onto the digit
// stack (a zero integer part skips the divider); characters then come out one per cycle:
// the integer digits popped from the stack, then the point and the fraction digits.
// One value at a time; busy is high until the last character is issued.
// Synchronous reset returns to idle with radix 10 and 10 fraction digits.
module value_to_radix_digits_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [vtrd_pkg::PORT_W-1:0]     int_part,
  input  logic [vtrd_pkg::PORT_W-1:0]     frac_part,
  input  logic                            cfg_we,
  input  logic [vtrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtrd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            strobe,
  output logic [vtrd_pkg::CHAR_W-1:0]     char_code,
  output logic                            last
);

  vtrd_pkg::cmd_t  cmd;
  vtrd_pkg::stat_t stat;

  vtrd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  vtrd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .int_part  (int_part),
    .frac_part (frac_part),
    .cmd       (cmd),
    .stat      (stat),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

endmodule

/* rtl/vtrd_checker.sv */
// vtrd_checker: port-level checks on the radix digit converter, bound to
// the top level. Depends on value_to_radix_digits_unit.
module vtrd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last
);

  // Every character comes out of a conversion in progress
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("character transfer without a conversion in progress");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted start did not raise busy");

  // The final character of a string closes the conversion
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy after the final character");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("conversion ended before the final character");

  a_fall_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (strobe && last))
    else $error("busy dropped without a final character transfer");

endmodule

bind value_to_radix_digits_unit vtrd_checker u_vtrd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);

/* bench/tb_top.sv */
// tb_top: self-checking bench for value_to_radix_digits_unit, a directed table
// followed by random phases, every character checked against the table text or a local predictor.
// Depends on vtrd_pkg and value_to_radix_digits_unit.
module tb_top;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 20;

  typedef struct packed {
    logic [vtrd_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_t;

  typedef struct {
    int                          radix_val;
    int                          prec_val;
    logic [vtrd_pkg::PORT_W-1:0] ival;
    logic [vtrd_pkg::PORT_W-1:0] fval;
    string                       text;
  } conv_row_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic [vtrd_pkg::PORT_W-1:0]     int_part;
  logic [vtrd_pkg::PORT_W-1:0]     frac_part;
  logic                            cfg_we;
  vtrd_pkg::cfg_idx_t              cfg_index;
  logic [vtrd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            strobe;
  logic [vtrd_pkg::CHAR_W-1:0]     char_code;
  logic                            last;

  // predictor copy of the registers
  logic [vtrd_pkg::RADIX_W-1:0] radix_reg;
  logic [vtrd_pkg::PREC_W-1:0]  prec_reg;

  char_t     pending_chars[$];
  conv_row_t conv_rows[$];
  int        fail_cnt = 0;

  value_to_radix_digits_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .int_part  (int_part),
    .frac_part (frac_part),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [vtrd_pkg::CHAR_W-1:0] ascii_of(input int unsigned d);
    if (d < 10) return vtrd_pkg::CHAR_ZERO + vtrd_pkg::CHAR_W'(d);
    return vtrd_pkg::CHAR_A + vtrd_pkg::CHAR_W'(d - 10);
  endfunction

  // Append one expected character at the tail of the queue.
  function automatic void queue_char(input char_t c);
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  // Expand one value into the characters the block should emit.
  function automatic void predict_chars(input logic [vtrd_pkg::PORT_W-1:0] ival,
                                        input logic [vtrd_pkg::PORT_W-1:0] fval);
    int unsigned base;
    int unsigned prec;
    int unsigned depth;
    int unsigned k;
    int unsigned digits[32];
    logic [31:0] quot;
    logic [31:0] frac;
    logic [63:0] prod;
    char_t       tail;
    base = int'(radix_reg);
    if (base < 2) base = 2;
    if (base > 36) base = 36;
    prec = int'(prec_reg);
    if (prec > vtrd_pkg::MAX_FRAC_DIGITS) prec = vtrd_pkg::MAX_FRAC_DIGITS;
    quot  = ival;
    frac  = fval;
    depth = 0;
    if (quot == 0) begin
      digits[0] = 0;
      depth = 1;
    end
    while (quot != 0) begin
      digits[depth] = quot % base;
      quot = quot / base;
      depth++;
    end
    for (k = depth; k > 0; k--) queue_char(char_t'{ascii_of(digits[k-1]), 1'b0});
    if (frac != 0) begin
      queue_char(char_t'{vtrd_pkg::CHAR_DOT, 1'b0});
      for (k = 0; k < prec; k++) begin
        prod = 64'(frac) * 64'(base);
        frac = prod[31:0];
        queue_char(char_t'{ascii_of(prod[63:32]), 1'b0});
        if (frac == 0) break;
      end
    end
    tail = pending_chars.pop_back();
    tail.last = 1'b1;
    queue_char(tail);
  endfunction

  function automatic void add_row(input int radix_val, input int prec_val,
                                  input logic [vtrd_pkg::PORT_W-1:0] ival,
                                  input logic [vtrd_pkg::PORT_W-1:0] fval,
                                  input string text);
    conv_row_t row;
    row = '{radix_val, prec_val, ival, fval, text};
    conv_rows.insert(conv_rows.size(), row);
  endfunction

  // Drop start and hold until every expected character is out and busy falls.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_chars.size() != 0 || busy);
  endtask

  task automatic write_config(input int radix_val, input int prec_val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= vtrd_pkg::CFG_RADIX;
    cfg_data  <= vtrd_pkg::CFG_DATA_W'(radix_val);
    @(negedge clk);
    cfg_index <= vtrd_pkg::CFG_FRAC_DIGITS;
    cfg_data  <= vtrd_pkg::CFG_DATA_W'(prec_val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    radix_reg = vtrd_pkg::RADIX_W'(radix_val);
    prec_reg  = vtrd_pkg::PREC_W'(prec_val);
  endtask

  // Called at a falling edge; returns at a falling edge, start still high if gap is 0.
  task automatic send_value(input logic [vtrd_pkg::PORT_W-1:0] ival,
                            input logic [vtrd_pkg::PORT_W-1:0] fval,
                            input string text, input int gap);
    byte ch;
    start     <= 1'b1;
    int_part  <= ival;
    frac_part <= fval;
    do @(posedge clk); while (busy);
    if (text == "") begin
      predict_chars(ival, fval);
    end else begin
      for (int k = 0; k < text.len(); k++) begin
        ch = text[k];
        queue_char(char_t'{ch[vtrd_pkg::CHAR_W-1:0], k == text.len() - 1});
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : check_chars
    char_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected char %h last %b", $time, char_code, last);
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code || last !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                     $time, want.code, want.last, char_code, last);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe) quiet = 0;
      else quiet++;
    end
    $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int                          cur_radix;
    int                          cur_prec;
    logic [vtrd_pkg::PORT_W-1:0] ival;
    logic [vtrd_pkg::PORT_W-1:0] fval;
    bit                          burst;
    rst       = 1'b1;
    start     = 1'b0;
    int_part  = '0;
    frac_part = '0;
    cfg_we    = 1'b0;
    cfg_index = vtrd_pkg::CFG_RADIX;
    cfg_data  = '0;
    radix_reg = vtrd_pkg::RADIX_RESET;
    prec_reg  = vtrd_pkg::PREC_RESET;
    cur_radix = int'(vtrd_pkg::RADIX_RESET);
    cur_prec  = int'(vtrd_pkg::PREC_RESET);

    // first rows run on the reset settings
    add_row(10, 10, 32'h0000_0000, 32'h0000_0000, "0");
    add_row(10, 10, 32'h0000_0001, 32'h0000_0000, "1");
    add_row(10, 10, 32'hFFFF_FFFF, 32'h0000_0000, "4294967295");
    add_row(10, 10, 32'h0000_0000, 32'h8000_0000, "0.5");
    add_row(16, 10, 32'hFFFF_FFFF, 32'h0000_0000, "FFFFFFFF");
    add_row(2, 10, 32'hFFFF_FFFF, 32'h0000_0000, "11111111111111111111111111111111");
    add_row(36, 10, 32'h0000_0023, 32'h0000_0000, "Z");
    // radix out of range saturates at both ends
    add_row(0, 10, 32'h0000_0005, 32'h0000_0000, "101");
    add_row(1, 10, 32'h0000_0006, 32'h0000_0000, "110");
    add_row(63, 10, 32'h0000_0023, 32'h0000_0000, "Z");
    add_row(37, 7, 32'hDEAD_BEEF, 32'h0000_FFFF, "");
    // zero precision still emits the point, which then ends the string
    add_row(2, 0, 32'h0000_0003, 32'h8000_0000, "11.");
    add_row(16, 30, 32'h0000_0000, 32'h0000_0001, "0.00000001");
    add_row(16, 30, 32'h8000_0000, 32'h8000_0000, "80000000.8");
    add_row(10, 1, 32'h0000_0000, 32'hC000_0000, "0.7");
    add_row(8, 5, 32'h0000_01FF, 32'h2000_0000, "777.1");
    // precision above the limit, and bit 5 of the data ignored
    add_row(10, 31, 32'h0000_0000, 32'h0000_0001, "");
    add_row(10, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, "");
    add_row(2, 30, 32'h0000_0000, 32'h5555_5555, "");
    add_row(3, 12, 32'h1234_5678, 32'hAAAA_AAAA, "");
    add_row(35, 20, 32'h89AB_CDEF, 32'h7654_3210, "");
    add_row(36, 30, 32'hFFFF_FFFF, 32'hFFFF_FFFF, "");

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (conv_rows[n]) begin
      if (conv_rows[n].radix_val != cur_radix || conv_rows[n].prec_val != cur_prec) begin
        write_config(conv_rows[n].radix_val, conv_rows[n].prec_val);
        cur_radix = conv_rows[n].radix_val;
        cur_prec  = conv_rows[n].prec_val;
      end
      send_value(conv_rows[n].ival, conv_rows[n].fval, conv_rows[n].text,
                 $urandom_range(0, 17));
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       write_config(2, 30);
        1:       write_config(36, 0);
        2:       write_config(0, 63);
        3:       write_config(63, 31);
        4:       write_config(10, 10);
        default: write_config($urandom_range(0, 63), $urandom_range(0, 63));
      endcase
      burst = (phase % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0:       ival = '0;
          1:       ival = '1;
          2, 3, 4: ival = $urandom >> $urandom_range(8, 31);
          default: ival = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0, 1:    fval = '0;
          2:       fval = '1;
          3, 4:    fval = $urandom << $urandom_range(20, 31);
          default: fval = $urandom;
        endcase
        send_value(ival, fval, "", burst ? 0 : $urandom_range(0, 17));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* value_to_radix_digits_unit.f */
rtl/vtrd_pkg.sv
rtl/vtrd_ctrl.sv
rtl/vtrd_dpath.sv
rtl/value_to_radix_digits_unit.sv
rtl/vtrd_checker.sv
bench/tb_top.sv
